FILE: design/stg_pkg.sv
// Shared types, constants and the sine table for the tone generator.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

	localparam int TABLE_SIZE = 64;
	localparam int PRESCALE   = 64;
	localparam int CLOCK_HZ   = 16000000;

	// floor(floor(a/b)/c) == floor(a/(b*c)), so the period divider only sees this
	localparam int CDIV      = CLOCK_HZ / (TABLE_SIZE * PRESCALE);
	localparam int CDIV_W    = $clog2(CDIV + 1);
	localparam int DIV_W     = (CDIV_W > 19) ? CDIV_W : 19;
	localparam int DIV_STEPS = 9;

	localparam logic [8:0] COUNT_MAX = 9'd511;
	localparam logic [9:0] MIDPOINT  = 10'd512;
	localparam logic [9:0] FULL_MAX  = 10'd1023;

	// x/100 for x < 2^16 as (x*RECIP) >> RECIP_SH
	localparam int RECIP_SH = 23;
	localparam logic [16:0] RECIP = 17'((2 ** RECIP_SH + 99) / 100);

	localparam logic [9:0] FREQ_RESET = 10'd440;
	localparam logic [6:0] AMPL_RESET = 7'd20;

	localparam logic [0:0] REG_TONE_FREQ = 1'b0;
	localparam logic [0:0] REG_AMPLITUDE = 1'b1;

	localparam logic [9:0] WAVE_ROM [64] = '{
		10'd512, 10'd562, 10'd612, 10'd660, 10'd707, 10'd752, 10'd794, 10'd833,
		10'd868, 10'd900, 10'd927, 10'd950, 10'd968, 10'd982, 10'd991, 10'd995,
		10'd995, 10'd991, 10'd982, 10'd968, 10'd950, 10'd927, 10'd900, 10'd868,
		10'd833, 10'd794, 10'd752, 10'd707, 10'd660, 10'd612, 10'd562, 10'd512,
		10'd461, 10'd411, 10'd363, 10'd316, 10'd271, 10'd229, 10'd190, 10'd155,
		10'd123, 10'd95,  10'd72,  10'd53,  10'd39,  10'd30,  10'd25,  10'd24,
		10'd28,  10'd37,  10'd50,  10'd68,  10'd90,  10'd116, 10'd146, 10'd180,
		10'd218, 10'd259, 10'd303, 10'd350, 10'd399, 10'd449, 10'd500, 10'd551
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE,
		ST_MUL1,
		ST_MUL2,
		ST_FIN
	} stg_state_t;

	typedef struct packed {
		logic div_load;
		logic div_step;
		logic decide;
		logic mul1;
		logic mul2;
		logic out_load;
	} stg_cmd_t;

	typedef struct packed {
		logic div_last;
		logic emit;
		logic out_free;
	} stg_stat_t;

endpackage

`default_nettype wire

FILE: design/sine_table_tone_generator.sv
// Sine table tone generator: top level joining controller and datapath.
// Input stream: one transfer per prescaled timer tick; s_tdata[0] is the tick flag.
// A zero tick is taken and changes nothing.
// Output stream: one transfer each time the tick counter reaches the tone period;
// m_tdata carries the scaled 10-bit sample and the 6-bit table index it came from.
// Period = CLOCK_HZ / (freq * TABLE_SIZE * PRESCALE), capped at 511 ticks; one
// sample goes out every period + 1 ticks.
// Config port: cfg_we with cfg_index 0 writes the tone frequency, 1 the amplitude
// in percent; write only while the block is idle.
// After a nonzero tick is taken, s_tready stays low through the 9-step period
// divider and the tick decision; a tick that yields a sample adds the two scaling
// multiply steps and the output load, which waits for a free output register.
// The sample is presented on m_tvalid once the output load has registered it.
// The output register decouples the sides: the next tick is taken while a sample
// waits; if the receiver still stalls when the following sample is ready, the
// block holds and keeps s_tready low until m_tready frees the register.
// Reset clears the tick counter, table index and output valid, and loads the
// registers with 440 Hz and 20 percent.
`timescale 1ns / 1ps
`default_nettype none

module sine_table_tone_generator
	import stg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] tick, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [9:0] dac_sample, [15:10] table_index
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	stg_cmd_t  cmd;
	stg_stat_t stat;

	stg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.tick     (s_tdata[0]),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("sample loaded over a pending output");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded sample not presented");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.div_load, cmd.div_step, cmd.decide, cmd.mul1, cmd.mul2, cmd.out_load}))
		else $error("more than one datapath command at once");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.mul1 || cmd.mul2) |-> !s_tready)
		else $error("input taken while an item is in progress");

endmodule

`default_nettype wire

FILE: design/stg_ctrl.sv
// Controller state machine: sequences the divider, tick decision, scaling steps and output load.
`timescale 1ns / 1ps
`default_nettype none

module stg_ctrl
	import stg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic      tick,
	output logic           s_tready,
	input  wire stg_stat_t stat,
	output stg_cmd_t       cmd
);

	stg_state_t state_q;
	stg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// a zero tick is taken and dropped
				if (s_tvalid && tick) begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.emit ? ST_MUL1 : ST_IDLE;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/stg_datapath.sv
// Datapath: config registers, period divider, tick counter, sample scaling, output register.
`timescale 1ns / 1ps
`default_nettype none

module stg_datapath
	import stg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire stg_cmd_t    cmd,
	output stg_stat_t        stat,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [15:0]      m_tdata
);

	logic [9:0]       freq_q;
	logic [6:0]       pct_q;
	logic [8:0]       tick_q;
	logic [5:0]       phase_q;
	logic [5:0]       idx_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [8:0]       quo_q;
	logic             sat_q;
	logic [3:0]       step_q;
	logic             neg_q;
	logic [15:0]      prod_q;
	logic [9:0]       quot_q;
	logic [9:0]       sample_q;
	logic [5:0]       out_idx_q;
	logic             out_valid_q;

	logic             rem_ge;
	logic [8:0]       period;
	logic [5:0]       phase_next;
	logic signed [10:0] centered;
	logic [9:0]       mag;
	logic [32:0]      wide;
	logic [10:0]      up_sum;
	logic [9:0]       sample_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
			pct_q  <= AMPL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TONE_FREQ: freq_q <= cfg_data;
				REG_AMPLITUDE: pct_q  <= cfg_data[6:0];
			endcase
		end
	end

	// restoring divider: CDIV / freq, one quotient bit per step
	assign rem_ge = (rem_q >= dvs_q);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q  <= DIV_W'(CDIV);
			dvs_q  <= DIV_W'({freq_q, 8'b0});
			sat_q  <= (DIV_W'({freq_q, 9'b0}) <= DIV_W'(CDIV));
			quo_q  <= '0;
			step_q <= 4'(DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q  <= {quo_q[7:0], rem_ge};
			dvs_q  <= dvs_q >> 1;
			step_q <= step_q - 4'd1;
		end
	end

	assign stat.div_last = (step_q == 4'd0);

	// quotient of 512 or more, or a zero frequency, saturates
	assign period     = sat_q ? COUNT_MAX : quo_q;
	assign stat.emit  = (tick_q >= period);
	assign phase_next = phase_q + 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= '0;
		end else if (cmd.decide) begin
			if (stat.emit) begin
				tick_q  <= '0;
				phase_q <= phase_next;
			end else begin
				tick_q <= tick_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			idx_q <= phase_q;
		end
	end

	// scale about the midpoint on the magnitude, sign reapplied at the end
	assign centered = $signed({1'b0, WAVE_ROM[idx_q]}) - $signed({1'b0, MIDPOINT});
	assign mag      = centered[10] ? 10'(-centered) : 10'(centered);
	assign wide     = 33'(prod_q) * 33'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			neg_q  <= centered[10];
			prod_q <= 16'(mag) * 16'(pct_q);
		end
		if (cmd.mul2) begin
			quot_q <= 10'(wide >> RECIP_SH);
		end
	end

	assign up_sum = {1'b0, MIDPOINT} + {1'b0, quot_q};

	always_comb begin
		if (neg_q) begin
			sample_d = (quot_q > MIDPOINT) ? 10'd0 : MIDPOINT - quot_q;
		end else begin
			sample_d = up_sum[10] ? FULL_MAX : up_sum[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q  <= sample_d;
			out_idx_q <= idx_q;
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = {out_idx_q, sample_q};

endmodule

`default_nettype wire
